>>> rtl/masked_bitslice_adder_top_assert.svh
// Assertion macros used by the checker file.
`ifndef MASKED_BITSLICE_ADDER_TOP_ASSERT_SVH
`define MASKED_BITSLICE_ADDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mba assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mba assertion failed");

`endif

>>> rtl/mba_pkg.sv
package mba_pkg;

    localparam int SHARE_FIELD_W = 64;
    localparam int RAND_FIELD_W  = 32;
    localparam int CFG_DATA_W    = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int PLANE_W       = 6;

    localparam int NSHARES_DEFAULT = 2;
    localparam int LANES_DEFAULT   = 32;

    localparam logic [PLANE_W-1:0] WORD_BITS_RESET = 6'd13;
    localparam logic [PLANE_W-1:0] WORD_BITS_MIN   = 6'd1;
    localparam logic [PLANE_W-1:0] WORD_BITS_MAX   = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_BITS   = 1'b0,
        REG_EXTRA_CARRY = 1'b1
    } reg_idx_t;

    // Per-plane control broadcast to every lane
    typedef struct packed {
        logic first;   // plane zero: carry input is not used
        logic update;  // load the new carry at this edge
    } lane_ctrl_t;

    typedef struct packed {
        logic [SHARE_FIELD_W-1:0] sum;
        logic [PLANE_W-1:0]       idx;
        logic                     last;
        logic                     done;
    } result_t;

    // PINI cross term for one share pair
    function automatic logic pini_bit(input logic a, input logic b, input logic r);
        pini_bit = (~a & r) ^ (a & (b ^ r));
    endfunction

endpackage

>>> rtl/mba_lane.sv
module mba_lane #(
    parameter int NSHARES = mba_pkg::NSHARES_DEFAULT,
    parameter int LANES   = mba_pkg::LANES_DEFAULT,
    parameter int LANE_ID = 0,
    parameter int NPAIRS  = NSHARES * (NSHARES - 1) / 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mba_pkg::lane_ctrl_t ctrl,
    input  logic [NSHARES-1:0]  x,
    input  logic [NSHARES-1:0]  y,
    input  logic [NPAIRS-1:0]   rnd,
    output logic [NSHARES-1:0]  sum,
    output logic [NSHARES-1:0]  carry_next
);

    logic [NSHARES-1:0] carry_reg;
    logic [NSHARES-1:0] share_ok;
    logic [NSHARES-1:0] a;
    logic [NSHARES-1:0] b;
    logic [NSHARES-1:0] xin;
    logic [NSHARES-1:0] t;

    // Share bits that fall past the packed field are dropped
    for (genvar d = 0; d < NSHARES; d++)
    begin : g_ok
        assign share_ok[d] = ((d * LANES + LANE_ID) < mba_pkg::SHARE_FIELD_W) ? 1'b1 : 1'b0;
    end

    always_comb
    begin
        if (ctrl.first)
        begin
            a   = x;
            b   = y;
            xin = '0;
        end
        else
        begin
            a   = x ^ y;
            b   = x ^ carry_reg;
            xin = x;
        end
    end

    always_comb
    begin
        int p;
        p = 0;
        t = a & b;
        for (int i = 0; i < NSHARES - 1; i++)
        begin
            for (int j = i + 1; j < NSHARES; j++)
            begin
                t[i] = t[i] ^ mba_pkg::pini_bit(a[i], b[j], rnd[p]);
                t[j] = t[j] ^ mba_pkg::pini_bit(a[j], b[i], rnd[p]);
                p = p + 1;
            end
        end
    end

    assign carry_next = (t ^ xin) & share_ok;
    assign sum = (x ^ y ^ (ctrl.first ? '0 : carry_reg)) & share_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else if (ctrl.update)
        begin
            carry_reg <= carry_next;
        end
    end

endmodule

>>> rtl/mba_outq.sv
module mba_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             need_two,
    input  mba_pkg::result_t res0,
    input  mba_pkg::result_t res1,
    input  logic             out_stall,
    output logic             full,
    output logic             out_valid,
    output mba_pkg::result_t head
);

    mba_pkg::result_t slot_reg [2];
    mba_pkg::result_t slot_next [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] cnt_pop;
    logic [2:0] need;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot_reg[0];
    assign pop       = out_valid & ~out_stall;
    assign cnt_pop   = cnt_reg - {1'b0, pop};
    assign need      = need_two ? 3'd2 : 3'd1;
    // room counts the slot freed by a transfer in the same cycle
    assign full      = (({1'b0, cnt_pop} + need) > 3'd2);

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_pop;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
        end
        if (push)
        begin
            if (cnt_pop == 2'd0)
            begin
                slot_next[0] = res0;
                slot_next[1] = res1;
            end
            else
            begin
                slot_next[1] = res0;
            end
            cnt_next = cnt_pop + (need_two ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

endmodule

>>> rtl/masked_bitslice_adder_top.sv
// Boolean-masked bitsliced ripple-carry adder. Each transfer on the input
// carries one bit plane (all shares of both operands plus one random lane
// word per share pair), least significant plane first; each plane gives one
// plane of sum shares, and with extra_carry_bit set the last plane also gives
// the carry-out plane. One input item is taken per clock unless in_stall is
// high; the masked carry is a single register per lane fed back per plane, so
// planes stream back to back. Results pass through a two-entry output queue:
// an item that yields two results needs both entries free (counting one
// leaving in the same cycle), so sustained output is one result per clock
// unless out_stall is high. word_bits and extra_carry_bit must be written
// only while idle (not enforced); writes do not clear carry or plane count.
module masked_bitslice_adder_top #(
    parameter int NSHARES = mba_pkg::NSHARES_DEFAULT,
    parameter int LANES   = mba_pkg::LANES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mba_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [mba_pkg::SHARE_FIELD_W-1:0]     first_shares,
    input  logic [mba_pkg::SHARE_FIELD_W-1:0]     second_shares,
    input  logic [mba_pkg::RAND_FIELD_W-1:0]      random_words,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [mba_pkg::SHARE_FIELD_W-1:0]     sum_shares,
    output logic [mba_pkg::PLANE_W-1:0]           plane_index,
    output logic                                  last_of_run,
    output logic                                  word_done
);

    localparam int NPAIRS = NSHARES * (NSHARES - 1) / 2;

    logic [mba_pkg::PLANE_W-1:0] word_bits_reg;
    logic                        extra_reg;
    logic [mba_pkg::PLANE_W-1:0] plane_reg;
    logic [mba_pkg::PLANE_W-1:0] plane_next;
    logic [mba_pkg::PLANE_W-1:0] bits_eff;
    logic                        is_last;
    logic                        two_res;
    logic                        accept;
    logic                        q_full;
    mba_pkg::lane_ctrl_t         ctrl;
    mba_pkg::result_t            res0;
    mba_pkg::result_t            res1;
    mba_pkg::result_t            head;

    logic [NSHARES-1:0] x_lane [LANES];
    logic [NSHARES-1:0] y_lane [LANES];
    logic [NPAIRS-1:0]  r_lane [LANES];
    logic [NSHARES-1:0] s_lane [LANES];
    logic [NSHARES-1:0] c_lane [LANES];
    logic [mba_pkg::SHARE_FIELD_W-1:0] sum_word;
    logic [mba_pkg::SHARE_FIELD_W-1:0] carry_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bits_reg <= mba_pkg::WORD_BITS_RESET;
            extra_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (mba_pkg::reg_idx_t'(cfg_index))
                mba_pkg::REG_WORD_BITS:   word_bits_reg <= cfg_data;
                mba_pkg::REG_EXTRA_CARRY: extra_reg     <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign bits_eff = (word_bits_reg == '0) ? mba_pkg::WORD_BITS_MIN :
                      ((word_bits_reg > mba_pkg::WORD_BITS_MAX) ? mba_pkg::WORD_BITS_MAX
                                                                 : word_bits_reg);
    // a count left past the end after word_bits was lowered acts as last
    assign is_last  = (plane_reg >= (bits_eff - 6'd1));
    assign two_res  = is_last & extra_reg;
    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    assign ctrl.first  = (plane_reg == '0);
    assign ctrl.update = accept & ~(~ctrl.first & is_last & ~extra_reg);

    assign plane_next = is_last ? '0 : plane_reg + 6'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (accept)
        begin
            plane_reg <= plane_next;
        end
    end

    // unpack shares and randomness into per-lane bit groups
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            x_lane[l] = '0;
            y_lane[l] = '0;
            r_lane[l] = '0;
        end
        for (int k = 0; k < mba_pkg::SHARE_FIELD_W; k++)
        begin
            if ((k / LANES) < NSHARES)
            begin
                x_lane[k % LANES][k / LANES] = first_shares[k];
                y_lane[k % LANES][k / LANES] = second_shares[k];
            end
        end
        for (int k = 0; k < mba_pkg::RAND_FIELD_W; k++)
        begin
            if ((k / LANES) < NPAIRS)
            begin
                r_lane[k % LANES][k / LANES] = random_words[k];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mba_lane #(
            .NSHARES (NSHARES),
            .LANES   (LANES),
            .LANE_ID (l),
            .NPAIRS  (NPAIRS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .x          (x_lane[l]),
            .y          (y_lane[l]),
            .rnd        (r_lane[l]),
            .sum        (s_lane[l]),
            .carry_next (c_lane[l])
        );
    end

    // merge lane outputs back into packed share words
    always_comb
    begin
        sum_word   = '0;
        carry_word = '0;
        for (int k = 0; k < mba_pkg::SHARE_FIELD_W; k++)
        begin
            if ((k / LANES) < NSHARES)
            begin
                sum_word[k]   = s_lane[k % LANES][k / LANES];
                carry_word[k] = c_lane[k % LANES][k / LANES];
            end
        end
    end

    assign res0.sum  = sum_word;
    assign res0.idx  = plane_reg;
    assign res0.last = ~two_res;
    assign res0.done = is_last & ~extra_reg;
    assign res1.sum  = carry_word;
    assign res1.idx  = bits_eff;
    assign res1.last = 1'b1;
    assign res1.done = 1'b1;

    mba_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .need_two  (two_res),
        .res0      (res0),
        .res1      (res1),
        .out_stall (out_stall),
        .full      (q_full),
        .out_valid (out_valid),
        .head      (head)
    );

    assign sum_shares  = head.sum;
    assign plane_index = head.idx;
    assign last_of_run = head.last;
    assign word_done   = head.done;

endmodule

>>> rtl/mba_checker.sv
`include "masked_bitslice_adder_top_assert.svh"

module mba_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [mba_pkg::SHARE_FIELD_W-1:0] sum_shares,
    input logic [mba_pkg::PLANE_W-1:0]       plane_index,
    input logic                              last_of_run,
    input logic                              word_done
);

    // a stalled result stays put
    `MBA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sum_shares) && $stable(plane_index) && $stable(word_done))
    // the final plane of a sum always closes its run
    `MBA_ASSERT_IMP(a_done_last, out_valid && word_done, last_of_run)
    // the carry-out plane is queued together with the plane before it
    `MBA_ASSERT_NXT(a_pair_follows, out_valid && !out_stall && !last_of_run, out_valid && word_done)
    `MBA_ASSERT_IMP(a_index_range, out_valid, plane_index <= 6'd32)

endmodule

bind masked_bitslice_adder_top mba_checker u_mba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sum_shares  (sum_shares),
    .plane_index (plane_index),
    .last_of_run (last_of_run),
    .word_done   (word_done)
);
